FILE: rtl/polygon_coverage_shader_unit_macros.svh
// ---------------------------------------------------------------------------
// Polygon coverage shader assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef POLYGON_COVERAGE_SHADER_UNIT_MACROS_SVH
`define POLYGON_COVERAGE_SHADER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define PCS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("polygon coverage shader: same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define PCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("polygon coverage shader: next-cycle check failed");

`endif

FILE: rtl/pcs_pkg.sv
// ---------------------------------------------------------------------------
// Polygon coverage shader package
// Shared payload types, control structs, state encodings and defaults.
// ---------------------------------------------------------------------------
package pcs_pkg;

    localparam int NUM_CORNERS_DEF    = 16;
    localparam int SUBSAMPLE_GRID_DEF = 4;

    localparam logic [7:0] CAP_RESET = 8'd255;

    // Request command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         vertex_index;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic [5:0]         pixel_x;
        logic [5:0]         pixel_y;
    } pcs_item_t;

    typedef struct packed {
        logic [4:0] covered_count;
        logic [7:0] red_level;
    } pcs_result_t;

    // One stored polygon vertex, Q8.8
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } pcs_vertex_t;

    typedef struct packed {
        logic clear;  // start a new pixel: drop the parity and the held vertex
        logic vin;    // a vertex from the store is on vtx
    } pcs_edge_ctl_t;

    typedef struct packed {
        logic busy;   // an edge is still in the compare pipeline
    } pcs_edge_stat_t;

    typedef struct packed {
        logic start;
    } pcs_lv_ctl_t;

    typedef struct packed {
        logic done;
    } pcs_lv_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_LEVEL,
        ST_DONE
    } pcs_state_t;

    typedef enum logic [2:0] {
        LV_IDLE,
        LV_SQ,
        LV_CUBE,
        LV_SCALE,
        LV_DIV,
        LV_DONE
    } pcs_lv_state_t;

endpackage

FILE: rtl/pcs_ram.sv
// ---------------------------------------------------------------------------
// Polygon coverage shader generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pcs_edge_unit.sv
// ---------------------------------------------------------------------------
// Polygon coverage shader edge unit
// Takes one vertex per cycle, forms the edge to the previous vertex and
// toggles the crossing parity of every subsample lane.
// ---------------------------------------------------------------------------
module pcs_edge_unit
    import pcs_pkg::*;
#(
    parameter int SUBSAMPLE_GRID = SUBSAMPLE_GRID_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pcs_edge_ctl_t                          ctl,
    input  pcs_vertex_t                            vtx,
    input  logic [5:0]                             pixel_x,
    input  logic [5:0]                             pixel_y,
    output pcs_edge_stat_t                         stat,
    output logic [SUBSAMPLE_GRID*SUBSAMPLE_GRID-1:0] parity
);

    localparam int G     = SUBSAMPLE_GRID;
    localparam int LANES = G * G;
    localparam int CW    = 17 + $clog2(G);   // scaled coordinate
    localparam int DW    = CW + 1;           // coordinate difference
    localparam int PW    = 2 * DW;           // cross product

    logic signed [CW-1:0] cur_x_reg, cur_y_reg, prv_x_reg, prv_y_reg;
    logic signed [CW-1:0] cur_x_next, cur_y_next;
    logic                 have_cur_reg, s0_valid_reg, s1_valid_reg;

    logic signed [CW-1:0] px [G];
    logic signed [CW-1:0] py [G];
    logic signed [DW-1:0] dy, dx;
    logic signed [DW-1:0] ax [G];
    logic signed [DW-1:0] by [G];
    logic signed [PW-1:0] lhs_next [G];
    logic signed [PW-1:0] rhs_next [G];
    logic signed [PW-1:0] lhs_reg [G];
    logic signed [PW-1:0] rhs_reg [G];
    logic [G-1:0]         cross_next, cross_reg;
    logic                 dypos_next, dypos_reg;
    logic [LANES-1:0]     par_reg, par_next;

    // Scale the incoming vertex to 1/(512*G) pixel
    assign cur_x_next = CW'(int'(vtx.x) * (2 * G));
    assign cur_y_next = CW'(int'(vtx.y) * (2 * G));

    // Sample positions in the same unit, one per column and row
    always_comb
    begin
        for (int s = 0; s < G; s++)
        begin
            px[s] = CW'((int'(pixel_x) * (2 * G) + 2 * s + 1) * 256);
            py[s] = CW'((int'(pixel_y) * (2 * G) + 2 * s + 1) * 256);
        end
    end

    // Edge differences and cross products; lhs depends on the column only,
    // rhs on the row only
    always_comb
    begin
        dy         = DW'(prv_y_reg) - DW'(cur_y_reg);
        dx         = DW'(prv_x_reg) - DW'(cur_x_reg);
        dypos_next = !dy[DW-1] && (dy != '0);
        for (int s = 0; s < G; s++)
        begin
            ax[s]         = DW'(px[s]) - DW'(cur_x_reg);
            by[s]         = DW'(py[s]) - DW'(cur_y_reg);
            lhs_next[s]   = PW'(ax[s]) * PW'(dy);
            rhs_next[s]   = PW'(dx) * PW'(by[s]);
            cross_next[s] = (cur_y_reg > py[s]) != (prv_y_reg > py[s]);
        end
    end

    always_comb
    begin
        par_next = par_reg;
        if (ctl.clear)
        begin
            par_next = '0;
        end
        else if (s1_valid_reg)
        begin
            for (int sy = 0; sy < G; sy++)
            begin
                for (int sx = 0; sx < G; sx++)
                begin
                    if (cross_reg[sy] &&
                        (dypos_reg ? (lhs_reg[sx] < rhs_reg[sy])
                                   : (lhs_reg[sx] > rhs_reg[sy])))
                    begin
                        par_next[sy*G+sx] = !par_reg[sy*G+sx];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.vin)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            prv_x_reg <= cur_x_reg;
            prv_y_reg <= cur_y_reg;
        end
        if (s0_valid_reg)
        begin
            for (int s = 0; s < G; s++)
            begin
                lhs_reg[s] <= lhs_next[s];
                rhs_reg[s] <= rhs_next[s];
            end
            cross_reg <= cross_next;
            dypos_reg <= dypos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_cur_reg <= 1'b0;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            par_reg      <= '0;
        end
        else
        begin
            have_cur_reg <= !ctl.clear && (have_cur_reg || ctl.vin);
            s0_valid_reg <= ctl.vin && have_cur_reg;
            s1_valid_reg <= s0_valid_reg;
            par_reg      <= par_next;
        end
    end

    assign stat.busy = s0_valid_reg || s1_valid_reg;
    assign parity    = par_reg;

endmodule

FILE: rtl/pcs_level_unit.sv
// ---------------------------------------------------------------------------
// Polygon coverage shader level unit
// Counts covered samples and forms round(cap * n^3 / G^6), one multiply per
// cycle, then a shift or a reciprocal multiply.
// ---------------------------------------------------------------------------
module pcs_level_unit
    import pcs_pkg::*;
#(
    parameter int SUBSAMPLE_GRID = SUBSAMPLE_GRID_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  pcs_lv_ctl_t                              ctl,
    input  logic [SUBSAMPLE_GRID*SUBSAMPLE_GRID-1:0] parity,
    input  logic [7:0]                               cap,
    output pcs_lv_stat_t                             stat,
    output pcs_result_t                              res
);

    localparam int G       = SUBSAMPLE_GRID;
    localparam int LANES   = G * G;
    localparam int NW      = $clog2(LANES + 1);
    localparam int NUMW    = 3 * NW + 9;
    localparam int DIVISOR = LANES * LANES * LANES;
    localparam int HALF    = DIVISOR / 2;
    localparam int SH      = $clog2(DIVISOR);
    localparam bit IS_POW2 = ((1 << SH) == DIVISOR);
    // Scaled reciprocal, exact for every numerator below 256 * DIVISOR
    localparam int              RSH   = 2 * SH + 8;
    localparam longint unsigned RECIP = ((64'd1 << RSH) + DIVISOR - 1) / DIVISOR;
    localparam int              PRODW = NUMW + RSH - SH + 2;

    pcs_lv_state_t state_reg, state_next;

    logic [NW-1:0]    n_reg, n_next;
    logic [2*NW-1:0]  sq_reg;
    logic [3*NW-1:0]  cube_reg;
    logic [NUMW-1:0]  num_reg, num_next;
    logic [NUMW-1:0]  shifted;
    logic [PRODW-1:0] prod;
    logic [7:0]       quot_reg, quot_next;
    logic [7:0]       red_next;
    logic [NW+4:0]    n_wide;
    pcs_result_t      res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LV_IDLE:  if (ctl.start) state_next = LV_SQ;
            LV_SQ:    state_next = LV_CUBE;
            LV_CUBE:  state_next = LV_SCALE;
            LV_SCALE: state_next = IS_POW2 ? LV_DONE : LV_DIV;
            LV_DIV:   state_next = LV_DONE;
            LV_DONE:  state_next = LV_IDLE;
            default:  state_next = LV_IDLE;
        endcase
    end

    always_comb
    begin
        n_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            n_next = n_next + NW'(parity[i]);
        end
    end

    // Divide by the constant through one multiply by its reciprocal
    assign prod    = PRODW'(num_reg) * PRODW'(RECIP);
    assign shifted = num_reg >> SH;

    always_comb
    begin
        num_next  = num_reg;
        quot_next = quot_reg;
        case (state_reg)
            LV_SCALE:
            begin
                num_next  = NUMW'(cube_reg) * NUMW'(cap) + NUMW'(HALF);
                quot_next = '0;
            end
            LV_DIV:
            begin
                quot_next = 8'(prod >> RSH);
            end
            default:
            begin
                num_next  = num_reg;
                quot_next = quot_reg;
            end
        endcase
    end

    assign red_next  = IS_POW2 ? shifted[7:0] : quot_reg;
    assign n_wide    = {5'b0, n_reg};
    assign stat.done = (state_reg == LV_DONE);
    assign res       = res_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == LV_IDLE && ctl.start)
        begin
            n_reg <= n_next;
        end
        if (state_reg == LV_SQ)
        begin
            sq_reg <= (2*NW)'(n_reg) * (2*NW)'(n_reg);
        end
        if (state_reg == LV_CUBE)
        begin
            cube_reg <= (3*NW)'(sq_reg) * (3*NW)'(n_reg);
        end
        num_reg  <= num_next;
        quot_reg <= quot_next;
        if (state_reg == LV_DONE)
        begin
            res_reg.covered_count <= n_wide[4:0];
            res_reg.red_level     <= red_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/polygon_coverage_shader_unit.sv
// ---------------------------------------------------------------------------
// Polygon coverage shader unit
// Supersampled even-odd point-in-polygon coverage with a cubic red level.
// ---------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): a write request stores one
//   Q8.8 vertex in the corner store and returns nothing.
//   A shade request names a pixel and returns one result on the result
//   channel (result_valid/result_ready/result): the count of covered
//   subsamples and round(cap * n^3 / G^6) as the red level.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes brightness_cap; it is
//   always ready and is meant to be written while no shade is in flight.
// Sequence: a shade reads NUM_CORNERS+1 vertices from the
//   store, one per cycle (the single store read port sets this), then drains
//   the edge pipeline, runs the level math (with an extra divide step when
//   G^6 is not a power of two) and loads the output register; item_ready
//   returns with the result, so the block takes no new request while a
//   shade is in flight.
// Stall: a finished result waits in the output register; write and shade
//   requests are still taken, and a second shade holds at its end until the
//   output register is free.
// Reset: clears control state and sets brightness_cap to 255, not the corner store;
//   the user must write every vertex before it is shaded; the block does not check.
// ---------------------------------------------------------------------------
`include "polygon_coverage_shader_unit_macros.svh"

module polygon_coverage_shader_unit
    import pcs_pkg::*;
#(
    parameter int NUM_CORNERS    = NUM_CORNERS_DEF,
    parameter int SUBSAMPLE_GRID = SUBSAMPLE_GRID_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  pcs_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output pcs_result_t result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int AW    = $clog2(NUM_CORNERS);
    localparam int CNTW  = $clog2(NUM_CORNERS + 1);
    localparam int LANES = SUBSAMPLE_GRID * SUBSAMPLE_GRID;

    pcs_state_t state_reg, state_next;

    logic [CNTW-1:0] rd_cnt_reg, rd_cnt_next, rd_sel;
    logic            rd_pend_reg;
    logic [5:0]      pix_x_reg, pix_y_reg;
    logic [7:0]      cap_reg;
    logic            out_valid_reg;
    pcs_result_t     out_reg;

    logic            accept, shade_accept, write_ok, drained, out_load;
    logic [AW+3:0]   idx_wide;
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [$bits(pcs_vertex_t)-1:0] ram_rdata;
    pcs_vertex_t     wr_vtx;

    pcs_edge_ctl_t   edge_ctl;
    pcs_edge_stat_t  edge_stat;
    logic [LANES-1:0] parity;
    pcs_lv_ctl_t     lv_ctl;
    pcs_lv_stat_t    lv_stat;
    pcs_result_t     lv_res;

    assign accept       = item_valid && item_ready;
    assign shade_accept = accept && (item.cmd == CMD_SHADE);

    // Drop vertex writes beyond the store
    assign idx_wide = {{AW{1'b0}}, item.vertex_index};
    assign write_ok = idx_wide < (AW+4)'(NUM_CORNERS);
    assign wr_vtx.x = item.vertex_x;
    assign wr_vtx.y = item.vertex_y;

    // Sweep order: last vertex first, so the first edge closes the polygon
    assign rd_sel    = (rd_cnt_reg == '0) ? CNTW'(NUM_CORNERS - 1) : rd_cnt_reg - 1'b1;
    assign ram_raddr = rd_sel[AW-1:0];

    assign drained  = !rd_pend_reg && !edge_stat.busy;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (shade_accept) state_next = ST_SWEEP;
            ST_SWEEP: if (rd_cnt_reg == CNTW'(NUM_CORNERS)) state_next = ST_DRAIN;
            ST_DRAIN: if (drained) state_next = ST_LEVEL;
            ST_LEVEL: if (lv_stat.done) state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || result_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        item_ready     = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        edge_ctl.clear = 1'b0;
        // Store data is valid in the cycle after the read is issued
        edge_ctl.vin   = rd_pend_reg;
        lv_ctl.start   = 1'b0;
        out_load       = 1'b0;
        rd_cnt_next    = rd_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready     = 1'b1;
                ram_we         = accept && (item.cmd == CMD_WRITE) && write_ok;
                edge_ctl.clear = shade_accept;
                rd_cnt_next    = '0;
            end
            ST_SWEEP:
            begin
                ram_re      = 1'b1;
                rd_cnt_next = rd_cnt_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                lv_ctl.start = drained;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || result_ready;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    pcs_ram #(
        .WIDTH ($bits(pcs_vertex_t)),
        .DEPTH (NUM_CORNERS)
    ) u_corner_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_wide[AW-1:0]),
        .wdata (wr_vtx),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pcs_edge_unit #(
        .SUBSAMPLE_GRID (SUBSAMPLE_GRID)
    ) u_edge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (edge_ctl),
        .vtx     (pcs_vertex_t'(ram_rdata)),
        .pixel_x (pix_x_reg),
        .pixel_y (pix_y_reg),
        .stat    (edge_stat),
        .parity  (parity)
    );

    pcs_level_unit #(
        .SUBSAMPLE_GRID (SUBSAMPLE_GRID)
    ) u_level (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lv_ctl),
        .parity (parity),
        .cap    (cap_reg),
        .stat   (lv_stat),
        .res    (lv_res)
    );

    // Hold the pixel for the whole sweep and the result until taken
    always_ff @(posedge clk)
    begin
        if (shade_accept)
        begin
            pix_x_reg <= item.pixel_x;
            pix_y_reg <= item.pixel_y;
        end
        if (out_load)
        begin
            out_reg <= lv_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            rd_pend_reg <= ram_re;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Level math starts only on a final parity vector
    `PCS_ASSERT_IMPLY(a_level_start_drained, lv_ctl.start, !edge_stat.busy && !rd_pend_reg)
    // Store data reaches the edge unit only in the sweep or the drain that follows
    `PCS_ASSERT_IMPLY(a_vertex_in_sweep, rd_pend_reg,
                      (state_reg == ST_SWEEP) || (state_reg == ST_DRAIN))
    // A shade request starts the sweep on the next cycle
    `PCS_ASSERT_NEXT(a_shade_starts_sweep, shade_accept,
                     (state_reg == ST_SWEEP) && (rd_cnt_reg == '0))

endmodule

FILE: bench/tb.sv
// ---------------------------------------------------------------------------
// Polygon coverage shader unit testbench
// Loads polygons vertex by vertex, shades pixels around them and checks every
// coverage count and red level against a scoreboard. The scoreboard keeps
// its own copy of the corner store and the brightness cap. Both channels
// idle at random, and one long result hold-off backs up the request side.
// ---------------------------------------------------------------------------
module tb;
    import pcs_pkg::*;

    localparam int CORNERS         = NUM_CORNERS_DEF;
    localparam int GRID            = SUBSAMPLE_GRID_DEF;
    localparam int SETTLE_CYCLES   = 40;      // beyond the shade latency
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 80;
    localparam int LIMIT_CYCLES    = 500_000;

    // Tracks the polygon held by the block and the results it should return.
    class coverage_scoreboard;
        pcs_vertex_t corners[CORNERS];
        logic [7:0]  cap;
        pcs_result_t pending_shades[$];
        int          mismatches;

        function new();
            cap        = CAP_RESET;
            mismatches = 0;
        endfunction

        function void set_cap(logic [7:0] value);
            cap = value;
        endfunction

        function int pending();
            return pending_shades.size();
        endfunction

        // Even-odd crossing test of one sample point, all in 1/(512*G) pixel
        function bit sample_inside(longint px, longint py);
            bit     odd;
            int     prev;
            longint xi, yi, xj, yj, dy, lhs, rhs;
            odd  = 1'b0;
            prev = CORNERS - 1;
            for (int cur = 0; cur < CORNERS; cur++)
            begin
                xi = longint'(corners[cur].x) * (2 * GRID);
                yi = longint'(corners[cur].y) * (2 * GRID);
                xj = longint'(corners[prev].x) * (2 * GRID);
                yj = longint'(corners[prev].y) * (2 * GRID);
                if ((yi > py) != (yj > py))
                begin
                    dy  = yj - yi;
                    lhs = (px - xi) * dy;
                    rhs = (xj - xi) * (py - yi);
                    if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
                        odd = !odd;
                end
                prev = cur;
            end
            return odd;
        endfunction

        function pcs_result_t shade_pixel(logic [5:0] pix_x, logic [5:0] pix_y);
            pcs_result_t res;
            int          n;
            int          red;
            longint      px, py;
            n = 0;
            for (int sy = 0; sy < GRID; sy++)
            begin
                py = (longint'(pix_y) * (2 * GRID) + 2 * sy + 1) * 256;
                for (int sx = 0; sx < GRID; sx++)
                begin
                    px = (longint'(pix_x) * (2 * GRID) + 2 * sx + 1) * 256;
                    if (sample_inside(px, py))
                        n++;
                end
            end
            red = (int'(cap) * n * n * n + (GRID ** 6) / 2) / (GRID ** 6);
            res.covered_count = n[4:0];
            res.red_level     = red[7:0];
            return res;
        endfunction

        function void note_request(pcs_item_t req);
            if (req.cmd == CMD_WRITE)
            begin
                corners[req.vertex_index].x = req.vertex_x;
                corners[req.vertex_index].y = req.vertex_y;
            end
            else
                pending_shades.push_back(shade_pixel(req.pixel_x, req.pixel_y));
        endfunction

        function void check_result(pcs_result_t got);
            pcs_result_t want;
            if (pending_shades.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no shade pending: count %0d red %0d",
                             got.covered_count, got.red_level);
                return;
            end
            want = pending_shades.pop_front();
            if (got.covered_count !== want.covered_count || got.red_level !== want.red_level)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected count %0d red %0d, got count %0d red %0d",
                             want.covered_count, want.red_level,
                             got.covered_count, got.red_level);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    pcs_item_t   item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    pcs_result_t result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    coverage_scoreboard sb = new();

    // calm: no idling on either side for the current phase
    bit calm = 1'b1;
    bit held_off = 1'b0;
    int stall_left = 0;
    int writes_sent = 0;
    int shades_sent = 0;
    int results_seen = 0;
    int cap_writes = 0;
    int scene_cx = 4;
    int scene_cy = 20;
    int scene_rad = 4;

    polygon_coverage_shader_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly back to back, often a short gap, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int clamp_pixel(int v);
        return (v < 0) ? 0 : (v > 63) ? 63 : v;
    endfunction

    // Offer one request, hold it until it is taken, then hand it to the scoreboard.
    // Valid stays high on return so that a back-to-back request needs no toggle.
    task automatic send_request(input pcs_item_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= req;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        sb.note_request(req);
        if (req.cmd == CMD_WRITE)
            writes_sent++;
        else
            shades_sent++;
    endtask

    // Pixel fields are don't-care on a write: randomize them.
    task automatic put_vertex(input int idx, input int x, input int y);
        pcs_item_t req;
        req.cmd          = CMD_WRITE;
        req.vertex_index = 4'(idx);
        req.vertex_x     = 16'(x);
        req.vertex_y     = 16'(y);
        req.pixel_x      = 6'($urandom_range(0, 63));
        req.pixel_y      = 6'($urandom_range(0, 63));
        send_request(req);
    endtask

    // Vertex fields are don't-care on a shade: randomize them.
    task automatic shade_at(input int px, input int py);
        pcs_item_t req;
        req.cmd          = CMD_SHADE;
        req.vertex_index = 4'($urandom_range(0, 15));
        req.vertex_x     = 16'($urandom_range(0, 65535));
        req.vertex_y     = 16'($urandom_range(0, 65535));
        req.pixel_x      = 6'(px);
        req.pixel_y      = 6'(py);
        send_request(req);
    endtask

    // Shade pixels on and just around the current polygon.
    task automatic shade_near(input int count);
        for (int k = 0; k < count; k++)
            shade_at(clamp_pixel(scene_cx + jitter(scene_rad + 1)),
                     clamp_pixel(scene_cy + jitter(scene_rad + 1)));
    endtask

    task automatic pick_scene();
        scene_cx  = $urandom_range(0, 63);
        scene_cy  = $urandom_range(0, 63);
        scene_rad = $urandom_range(1, 10);
    endtask

    // Sixteen random points in a box: a tangled polygon, many partial counts.
    task automatic scatter_scene();
        pick_scene();
        for (int k = 0; k < CORNERS; k++)
            put_vertex(k, scene_cx * 256 + jitter(scene_rad * 256),
                       scene_cy * 256 + jitter(scene_rad * 256));
        shade_near($urandom_range(3, 8));
    endtask

    // Axis-aligned box with fractional edges: full, empty and edge pixels,
    // horizontal edges, and repeated vertices closing the ring.
    task automatic box_scene();
        int x0, x1, y0, y1;
        pick_scene();
        x0 = scene_cx * 256 - int'($urandom_range(0, scene_rad * 256));
        x1 = scene_cx * 256 + int'($urandom_range(0, scene_rad * 256));
        y0 = scene_cy * 256 - int'($urandom_range(0, scene_rad * 256));
        y1 = scene_cy * 256 + int'($urandom_range(0, scene_rad * 256));
        put_vertex(0, x0, y0);
        put_vertex(1, x1, y0);
        put_vertex(2, x1, y1);
        for (int k = 3; k < CORNERS; k++)
            put_vertex(k, x0, y1);
        shade_near($urandom_range(3, 8));
    endtask

    // Move a few vertices of the polygon in place, then shade again.
    task automatic tweak_scene();
        int moves;
        moves = $urandom_range(1, 3);
        for (int k = 0; k < moves; k++)
            put_vertex($urandom_range(0, CORNERS - 1),
                       scene_cx * 256 + jitter(scene_rad * 256),
                       scene_cy * 256 + jitter(scene_rad * 256));
        shade_near($urandom_range(2, 4));
    endtask

    // Full-range vertices and pixels anywhere on the screen.
    task automatic noise_burst();
        int count;
        count = $urandom_range(2, 6);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 1) == 0)
                put_vertex($urandom_range(0, CORNERS - 1),
                           $urandom_range(0, 65535), $urandom_range(0, 65535));
            else
                shade_at($urandom_range(0, 63), $urandom_range(0, 63));
        end
    endtask

    // Write the cap only once every shade has come back and the block is quiet.
    task automatic set_cap(input logic [7:0] value);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_cap(value);
        cap_writes++;
    endtask

    // Result side: check every taken result, stall at random, and hold off
    // once for a long stretch so the block fills and stalls its input.
    initial
    begin
        int r;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                sb.check_result(result);
                results_seen++;
            end
            if (!held_off && results_seen >= 40)
            begin
                held_off   = 1'b1;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (calm)
                result_ready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    result_ready <= 1'b1;
                else
                begin
                    result_ready <= 1'b0;
                    stall_left = (r < 96) ? $urandom_range(0, 3) : $urandom_range(8, 50);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [7:0] caps[6];
        int         goal;
        int         r;
        int         failures;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a box from (2.0, 2.375) to (6.5, 64.0) whose top edge lies
        // exactly on a sample row; the rest of the ring repeats the last corner.
        put_vertex(0, 512, 608);
        put_vertex(1, 1664, 608);
        put_vertex(2, 1664, 16384);
        for (int k = 3; k < CORNERS; k++)
            put_vertex(k, 512, 16384);
        shade_at(2, 2);
        shade_at(6, 2);
        shade_at(0, 0);
        shade_at(63, 63);
        shade_at(4, 40);
        // Extreme coordinates at both ends of the signed range
        put_vertex(14, -32768, 32767);
        put_vertex(15, 32767, -32768);
        shade_at(63, 0);
        shade_at(0, 63);

        // Random phases, each under its own cap; both extremes of the cap included
        caps[0] = 8'd0;
        caps[1] = 8'd255;
        caps[2] = 8'd1;
        caps[3] = 8'($urandom_range(2, 254));
        caps[4] = 8'd128;
        caps[5] = 8'($urandom_range(0, 255));
        for (int ph = 0; ph < 6; ph++)
        begin
            set_cap(caps[ph]);
            calm = (ph == 2);
            goal = writes_sent + shades_sent + PHASE_ITEMS;
            while (writes_sent + shades_sent < goal)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    scatter_scene();
                else if (r < 65)
                    box_scene();
                else if (r < 85)
                    tweak_scene();
                else
                    noise_burst();
            end
        end
        item_valid <= 1'b0;

        // Drain what is still in flight, then leave room for a stray result
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        failures = sb.mismatches + sb.pending();
        $display("Ran %0d vertex writes and %0d shades under %0d cap settings.",
                 writes_sent, shades_sent, cap_writes + 1);
        $display("Checked %0d results with %0d mismatches, long result hold-off %0s.",
                 results_seen, sb.mismatches, held_off ? "done" : "not reached");
        if (failures == 0)
            $display("polygon_coverage_shader_unit test passed");
        else
            $display("polygon_coverage_shader_unit test failed");
        $finish;
    end

    // Watchdog: cut the run off well beyond the slowest legal finish
    initial
    begin
        #(LIMIT_CYCLES * 4);
        $display("Watchdog expired with %0d shades outstanding.", sb.pending());
        $display("polygon_coverage_shader_unit test failed");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/pcs_pkg.sv
rtl/pcs_ram.sv
rtl/pcs_edge_unit.sv
rtl/pcs_level_unit.sv
rtl/polygon_coverage_shader_unit.sv
bench/tb.sv
